/* hw/rtl/m2e_pkg.sv */
// Package with shared constants and a helper function for the 2x2 eigen decomposition block.
`timescale 1ns / 1ps
package m2e_pkg;

	localparam int ELEM_W = 32;
	localparam int EPS_W = 31;
	localparam int S_W = 66;
	localparam int ROOT_W = 33;

	// Clamp a 35-bit signed value into the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
		logic signed [34:0] hi;
		logic signed [34:0] lo;
		hi = 35'sd2147483647;
		lo = -35'sd2147483648;
		if (x > hi) begin
			sat32 = 32'sh7fffffff;
		end else if (x < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

endpackage

/* hw/rtl/m2e_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module m2e_isqrt #(
	parameter int IN_W = 66,
	parameter int OUT_W = 33,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [IN_W-1:0]  radicand,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [OUT_W-1:0] root,
	output logic [TAG_W-1:0] out_tag
);

	// Each stage decides one root bit from the top down (restoring method).
	logic             vld_q [OUT_W];
	logic [IN_W-1:0]  rem_q [OUT_W];
	logic [OUT_W-1:0] res_q [OUT_W];
	logic [TAG_W-1:0] tag_q [OUT_W];

	for (genvar i = 0; i < OUT_W; i++) begin : g_stage
		localparam int B = OUT_W - 1 - i;
		logic             vld_in;
		logic [IN_W-1:0]  rem_in;
		logic [OUT_W-1:0] res_in;
		logic [TAG_W-1:0] tag_in;
		logic [IN_W+1:0]  trial;
		logic [IN_W+1:0]  remw;
		logic [IN_W+1:0]  resw;
		if (i == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = radicand;
			assign res_in = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_q[i-1];
			assign rem_in = rem_q[i-1];
			assign res_in = res_q[i-1];
			assign tag_in = tag_q[i-1];
		end
		always_comb begin
			resw = (IN_W + 2)'(res_in);
			remw = (IN_W + 2)'(rem_in);
			trial = ((resw << 1) | ((IN_W + 2)'(1) << B)) << B;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else begin
				vld_q[i] <= vld_in;
			end
		end
		always_ff @(posedge clk) begin
			tag_q[i] <= tag_in;
			if (remw >= trial) begin
				rem_q[i] <= IN_W'(remw - trial);
				res_q[i] <= res_in | (OUT_W'(1) << B);
			end else begin
				rem_q[i] <= rem_in;
				res_q[i] <= res_in;
			end
		end
	end

	assign out_valid = vld_q[OUT_W-1];
	assign root = res_q[OUT_W-1];
	assign out_tag = tag_q[OUT_W-1];

endmodule

/* hw/rtl/matrix2x2_eigen_decomposition.sv */
// Top level of the pipelined 2x2 eigen decomposition block.
`timescale 1ns / 1ps
// The block takes one 2x2 matrix in signed fixed point per clock (start while
// busy is low; busy is always low here) and delivers one result per matrix,
// in order, marked by done for exactly one cycle. Two stages form the
// trace, difference and the products, one sums them into the
// half-discriminant S, 33 stages of the square-root unit resolve one root bit
// each, and two final stages form the eigenvalues and the saturated vectors.
// The square-root unit sets the latency; throughput is one transfer per cycle.
// When S is negative the eigenvalues are complex: valid_res is low and every
// other field is zero. The epsilon register may be written only while no
// matrix is in flight; the receiver cannot stall, so results are never held.
module matrix2x2_eigen_decomposition #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] elem_00,
	input  logic signed [31:0] elem_01,
	input  logic signed [31:0] elem_10,
	input  logic signed [31:0] elem_11,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata,
	output logic               done,
	output logic               valid_res,
	output logic signed [31:0] eig_first,
	output logic signed [31:0] eig_second,
	output logic signed [31:0] vec_first_x,
	output logic signed [31:0] vec_first_y,
	output logic signed [31:0] vec_second_x,
	output logic signed [31:0] vec_second_y
);

	localparam int TAG_W = 4 * 32;

	logic [30:0] epsilon_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= 31'd7;
		end else if (cfg_we) begin
			epsilon_q <= cfg_wdata;
		end
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Stage 1: trace and difference.
	logic               vld_s1;
	logic signed [32:0] t_s1, u_s1;
	logic signed [31:0] a_s1, b_s1, c_s1, d_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		t_s1 <= 33'(elem_00) + 33'(elem_11);
		u_s1 <= 33'(elem_00) - 33'(elem_11);
		a_s1 <= elem_00;
		b_s1 <= elem_01;
		c_s1 <= elem_10;
		d_s1 <= elem_11;
	end

	// Stage 2: the two products.
	logic               vld_s2;
	logic [64:0]        uu_s2;
	logic signed [63:0] bc_s2;
	logic signed [32:0] t_s2;
	logic signed [31:0] a_s2, b_s2, c_s2, d_s2;
	logic [32:0]        um;
	assign um = u_s1[32] ? 33'(-u_s1) : 33'(u_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		uu_s2 <= 65'(66'(um) * 66'(um));
		bc_s2 <= 64'(b_s1) * 64'(c_s1);
		t_s2 <= t_s1;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		c_s2 <= c_s1;
		d_s2 <= d_s1;
	end

	// Stage 3: S = floor(U*U/4) + b*c.
	logic               vld_s3;
	logic signed [65:0] s_s3;
	logic signed [32:0] t_s3;
	logic signed [31:0] a_s3, b_s3, c_s3, d_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		s_s3 <= $signed(66'(uu_s2 >> 2)) + 66'(bc_s2);
		t_s3 <= t_s2;
		a_s3 <= a_s2;
		b_s3 <= b_s2;
		c_s3 <= c_s2;
		d_s3 <= d_s2;
	end

	// Square root; the negative flag and the sidecar travel alongside.
	logic [m2e_pkg::S_W-1:0] rad;
	assign rad = s_s3[65] ? '0 : s_s3;

	logic [TAG_W-1:0] tag_in, tag_out;
	assign tag_in = {a_s3, b_s3, c_s3, d_s3};

	// Short side line for t and the sign of S, matched to the root latency.
	logic [m2e_pkg::ROOT_W-1:0][33:0] side_q;
	always_ff @(posedge clk) begin
		side_q[0] <= {s_s3[65], t_s3};
		for (int k = 1; k < m2e_pkg::ROOT_W; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	logic                     sq_vld;
	logic [m2e_pkg::ROOT_W-1:0] sq_root;
	m2e_isqrt #(
		.IN_W (m2e_pkg::S_W),
		.OUT_W(m2e_pkg::ROOT_W),
		.TAG_W(TAG_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.radicand (rad),
		.in_tag   (tag_in),
		.out_valid(sq_vld),
		.root     (sq_root),
		.out_tag  (tag_out)
	);

	// Stage 4: eigenvalues at full width, vector source choice.
	logic               vld_s4, neg_s4;
	logic signed [34:0] e1_s4, e2_s4;
	logic signed [31:0] a_s4, b_s4, c_s4, d_s4;
	logic               useb_s4, usec_s4;
	logic signed [32:0] t_w;
	logic signed [35:0] sum1, sum2;
	logic [31:0]        bmag, cmag;
	logic signed [31:0] ta, tb, tc, td;
	assign {ta, tb, tc, td} = tag_out;
	assign t_w  = side_q[m2e_pkg::ROOT_W-1][32:0];
	assign sum1 = 36'(t_w) + 36'($signed({1'b0, sq_root, 1'b0}));
	assign sum2 = 36'(t_w) - 36'($signed({1'b0, sq_root, 1'b0}));
	assign bmag = tb[31] ? 32'(-tb) : 32'(tb);
	assign cmag = tc[31] ? 32'(-tc) : 32'(tc);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end
	always_ff @(posedge clk) begin
		neg_s4 <= side_q[m2e_pkg::ROOT_W-1][33];
		e1_s4 <= 35'(sum1 >>> 1);
		e2_s4 <= 35'(sum2 >>> 1);
		useb_s4 <= bmag > {1'b0, epsilon_q};
		usec_s4 <= cmag > {1'b0, epsilon_q};
		a_s4 <= ta;
		b_s4 <= tb;
		c_s4 <= tc;
		d_s4 <= td;
	end

	// Stage 5: vectors, saturation and the output register.
	logic signed [34:0] v1x, v1y, v2x, v2y;
	always_comb begin
		if (useb_s4) begin
			v1x = e1_s4 - 35'(d_s4);
			v1y = 35'(b_s4);
			v2x = e2_s4 - 35'(d_s4);
			v2y = 35'(b_s4);
		end else if (usec_s4) begin
			v1x = 35'(c_s4);
			v1y = e1_s4 - 35'(a_s4);
			v2x = 35'(c_s4);
			v2y = e2_s4 - 35'(a_s4);
		end else begin
			v1x = 35'(1) << FRAC_BITS;
			v1y = '0;
			v2x = '0;
			v2y = 35'(1) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (neg_s4) begin
			valid_res <= 1'b0;
			eig_first <= '0;
			eig_second <= '0;
			vec_first_x <= '0;
			vec_first_y <= '0;
			vec_second_x <= '0;
			vec_second_y <= '0;
		end else begin
			valid_res <= 1'b1;
			eig_first <= m2e_pkg::sat32(e1_s4);
			eig_second <= m2e_pkg::sat32(e2_s4);
			vec_first_x <= m2e_pkg::sat32(v1x);
			vec_first_y <= m2e_pkg::sat32(v1y);
			vec_second_x <= m2e_pkg::sat32(v2x);
			vec_second_y <= m2e_pkg::sat32(v2y);
		end
	end

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_res |-> eig_first >= eig_second)
		else $error("eigenvalues out of order");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |=> done)
		else $error("result lost at output");
	a_cplx: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> eig_first == 0 && vec_first_x == 0)
		else $error("complex case not zeroed");
`endif

endmodule
